// File: sv/bmhq_pkg.sv
// shared constants, codes and item types of the binary min-heap queue
`default_nettype none

package bmhq_pkg;

   // heap size and derived widths
   localparam int CAPACITY = 128;
   localparam int NODE_W   = $clog2(CAPACITY + 1);   // 1-based node number, up to CAPACITY
   localparam int LEVELS   = NODE_W;                 // one cell per tree level
   localparam int ROW_W    = NODE_W - 1;             // row number of a pair of siblings
   localparam int LEVEL_W  = $clog2(LEVELS);

   localparam int KEY_W    = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 8;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_EXTRACT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK    = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MINIMUM  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]     action;
      logic signed [KEY_W-1:0] key_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] key_out;
      logic [HELD_W-1:0]       entries_held;
   } rsp_type;

   // token walking down the chain of level cells
   typedef enum logic {
      OP_INS = 1'b0,
      OP_DEL = 1'b1
   } op_type;

   typedef struct packed {
      logic                    valid;
      op_type                  op;
      logic [NODE_W-1:0]       node;    // insert: node here; sift down: parent one level up
      logic signed [KEY_W-1:0] key;
      logic [NODE_W-1:0]       limit;   // insert: target node; sift down: entries held
      logic [NODE_W-1:0]       path;    // insert: remaining path bits, msb first
   } tok_type;

   // single key write at a node
   typedef struct packed {
      logic                    valid;
      logic [NODE_W-1:0]       node;
      logic signed [KEY_W-1:0] key;
   } wup_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] node;
   } probe_type;

   // one row holds two siblings, lane 0 the even node
   typedef logic [1:0][KEY_W-1:0] row_type;

   typedef struct packed {
      logic             rd_en;
      logic [ROW_W-1:0] rd_row;
      logic [1:0]       wr_lane;
      logic [ROW_W-1:0] wr_row;
      logic [KEY_W-1:0] wr_key;
   } ram_ctrl_type;

endpackage

`default_nettype wire

// File: sv/bmhq_ram.sv
// row memory of one heap level: two key lanes, one write and one registered read port
`default_nettype none

module bmhq_ram #(
   parameter int DEPTH = 2,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output bmhq_pkg::row_type               rd_data,
   input  wire logic [1:0]                 wr_lane,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [bmhq_pkg::KEY_W-1:0] wr_key
);

   bmhq_pkg::row_type mem [DEPTH];
   bmhq_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_lane[0]) begin
         mem[wr_addr][0] <= wr_key;
      end
      if (wr_lane[1]) begin
         mem[wr_addr][1] <= wr_key;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/bmhq_cell.sv
// one level cell of the heap chain: insert and sift-down steps on its own level
`default_nettype none

module bmhq_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bmhq_pkg::tok_type   tok_in,
   input  wire bmhq_pkg::wup_type   wup_in,
   input  wire bmhq_pkg::probe_type probe_in,
   input  wire bmhq_pkg::row_type   rd_data,
   output bmhq_pkg::ram_ctrl_type   ram,
   output bmhq_pkg::tok_type        tok_out,
   output bmhq_pkg::wup_type        wup_out,
   output logic                     done,
   output logic [bmhq_pkg::KEY_W-1:0] probe_key
);

   localparam int NW = bmhq_pkg::NODE_W;
   localparam int RW = bmhq_pkg::ROW_W;
   localparam int KW = bmhq_pkg::KEY_W;

   logic              pend_ff, pend_in;
   logic              done_ff, done_in;
   logic              plane_ff;
   bmhq_pkg::tok_type tok_ff;

   logic              target_hit;
   logic [KW-1:0]     cur_key, left_key, right_key, pick_key;
   logic [NW-1:0]     left_node, right_node, pick_node;
   logic              left_ok, right_ok, take_right;
   logic              ins_swap, del_go, del_deeper;
   bmhq_pkg::wup_type own_wr, wr;

   // insert reaching its empty target slot writes at once
   assign target_hit = tok_in.valid && (tok_in.op == bmhq_pkg::OP_INS) &&
                       (tok_in.node == tok_in.limit);
   assign pend_in    = tok_in.valid && !target_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_in.valid) begin
         tok_ff <= tok_in;
      end
      if (probe_in.en) begin
         plane_ff <= probe_in.node[0];
      end
   end

   // evaluation of the token latched last cycle
   always_comb begin
      cur_key    = rd_data[tok_ff.node[0]];
      left_key   = rd_data[0];
      right_key  = rd_data[1];
      left_node  = {tok_ff.node[NW-2:0], 1'b0};
      right_node = {tok_ff.node[NW-2:0], 1'b1};
      left_ok    = left_node <= tok_ff.limit;
      right_ok   = right_node <= tok_ff.limit;
      // ties go to the left child
      take_right = right_ok && ($signed(left_key) > $signed(right_key));
      pick_key   = take_right ? right_key : left_key;
      pick_node  = take_right ? right_node : left_node;
      ins_swap   = $signed(cur_key) > tok_ff.key;
      del_go     = left_ok && (tok_ff.key > $signed(pick_key));
      del_deeper = {pick_node, 1'b0} <= {1'b0, tok_ff.limit};

      tok_out = '0;
      wup_out = '0;
      own_wr  = '0;
      done_in = 1'b0;

      if (target_hit) begin
         own_wr.valid = 1'b1;
         own_wr.node  = tok_in.node;
         own_wr.key   = tok_in.key;
         done_in      = 1'b1;
      end

      if (pend_ff) begin
         unique case (tok_ff.op)
            bmhq_pkg::OP_INS: begin
               // larger resident key is pushed further down the path
               if (ins_swap) begin
                  own_wr.valid = 1'b1;
                  own_wr.node  = tok_ff.node;
                  own_wr.key   = tok_ff.key;
               end
               tok_out.valid = 1'b1;
               tok_out.op    = bmhq_pkg::OP_INS;
               tok_out.node  = {tok_ff.node[NW-2:0], tok_ff.path[NW-2]};
               tok_out.key   = ins_swap ? $signed(cur_key) : tok_ff.key;
               tok_out.limit = tok_ff.limit;
               tok_out.path  = {tok_ff.path[NW-2:0], 1'b0};
            end
            bmhq_pkg::OP_DEL: begin
               // parent slot one level up is always filled from here
               wup_out.valid = 1'b1;
               wup_out.node  = tok_ff.node;
               wup_out.key   = del_go ? $signed(pick_key) : tok_ff.key;
               if (del_go && del_deeper) begin
                  tok_out.valid = 1'b1;
                  tok_out.op    = bmhq_pkg::OP_DEL;
                  tok_out.node  = pick_node;
                  tok_out.key   = tok_ff.key;
                  tok_out.limit = tok_ff.limit;
                  tok_out.path  = '0;
               end else if (del_go) begin
                  own_wr.valid = 1'b1;
                  own_wr.node  = pick_node;
                  own_wr.key   = tok_ff.key;
                  done_in      = 1'b1;
               end else begin
                  done_in = 1'b1;
               end
            end
            default: begin
               done_in = 1'b0;
            end
         endcase
      end
   end

   // memory port: read for the incoming token or probe; write from the level below,
   // else own write
   always_comb begin
      ram.rd_en = pend_in || probe_in.en;
      if (probe_in.en) begin
         ram.rd_row = probe_in.node[NW-1:1];
      end else if (tok_in.op == bmhq_pkg::OP_INS) begin
         ram.rd_row = tok_in.node[NW-1:1];
      end else begin
         ram.rd_row = tok_in.node[RW-1:0];   // children row equals parent number
      end
      wr          = wup_in.valid ? wup_in : own_wr;
      ram.wr_lane = wr.valid ? (wr.node[0] ? 2'b10 : 2'b01) : 2'b00;
      ram.wr_row  = wr.node[NW-1:1];
      ram.wr_key  = wr.key;
   end

   assign probe_key = rd_data[plane_ff];
   assign done      = done_ff;

endmodule

`default_nettype wire

// File: sv/binary_min_heap_queue_core.sv
// top level of the binary min-heap priority queue: sequencer and chain of level cells
`default_nettype none

// Binary min-heap of signed 32-bit keys, one item at a time. Raise start with
// an item on req_data while busy is low; the item is taken at that edge. Its
// single result appears on rsp_data for exactly one cycle with rsp_valid high
// and must be captured then, as the block cannot be held off. The heap is a
// chain of level cells, one per tree level, each owning the row memory of its
// level; an insert or sift-down token steps one level per clock. An insert
// walks its token from the root down the path to the new slot; an extract
// reads the root and the last entry, then sinks the moved key from level one
// on; a peek, an extract of the only key and an item refused on a full or
// empty heap are answered without a token walk. The heap memories need no
// clearing pass after reset; reset clears the entry count and the control
// registers only.
module binary_min_heap_queue_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire bmhq_pkg::req_type req_data,
   output logic              rsp_valid,
   output bmhq_pkg::rsp_type rsp_data
);

   localparam int NW  = bmhq_pkg::NODE_W;
   localparam int L   = bmhq_pkg::LEVELS;
   localparam int LW  = bmhq_pkg::LEVEL_W;
   localparam int KW  = bmhq_pkg::KEY_W;
   localparam int HW  = bmhq_pkg::HELD_W;
   localparam int CAP = bmhq_pkg::CAPACITY;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROBE = 3'b010,
      ST_WAIT  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   logic          ins_ff, ins_in;
   logic          ext_ff, ext_in;
   logic [LW-1:0] dc_ff, dc_in;
   logic [KW-1:0] root_ff, root_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::rsp_type rsp_ff, rsp_in;

   // level of a 1-based node: position of its leading one
   function automatic logic [LW-1:0] node_level(input logic [NW-1:0] n);
      logic [LW-1:0] r;
      r = '0;
      for (int b = 0; b < NW; b++) begin
         if (n[b]) begin
            r = LW'(b);
         end
      end
      return r;
   endfunction

   // node number shifted so that its leading one sits at the msb
   function automatic logic [NW-1:0] node_path(input logic [NW-1:0] n);
      logic [NW-1:0] r;
      r = '0;
      for (int b = 0; b < NW; b++) begin
         if (n[b]) begin
            r = n << (NW - 1 - b);
         end
      end
      return r;
   endfunction

   // chain wiring
   bmhq_pkg::tok_type      tok_in_vec  [L];
   bmhq_pkg::tok_type      tok_out_vec [L];
   bmhq_pkg::wup_type      wup_in_vec  [L];
   bmhq_pkg::wup_type      wup_out_vec [L];
   bmhq_pkg::probe_type    probe_vec   [L];
   bmhq_pkg::row_type      rd_data_vec [L];
   bmhq_pkg::ram_ctrl_type ram_vec     [L];
   logic [KW-1:0]          probe_key_vec [L];
   logic [L-1:0]           done_vec;

   logic              accept, any_done;
   logic              is_insert, is_extract, heap_full, heap_empty;
   logic              probe_go;
   logic [LW-1:0]     last_level;
   logic [NW-1:0]     count_less;
   logic [KW-1:0]     root_key;
   bmhq_pkg::tok_type ins_tok, del_tok;

   assign accept     = start && !busy;
   assign any_done   = |done_vec;
   assign is_insert  = req_data.action == bmhq_pkg::ACT_INSERT;
   assign is_extract = req_data.action == bmhq_pkg::ACT_EXTRACT;
   assign heap_full  = count_ff == NW'(CAP);
   assign heap_empty = count_ff == '0;
   assign last_level = node_level(count_ff);
   assign count_less = count_ff - NW'(1);
   assign root_key   = probe_key_vec[0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ins_in       = ins_ff;
      ext_in       = ext_ff;
      dc_in        = dc_ff;
      root_in      = root_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      probe_go     = 1'b0;
      ins_tok      = '0;
      del_tok      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_insert && heap_full) begin
                  // dropped, nothing changes
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = bmhq_pkg::STAT_FULL;
                  rsp_in.key_out      = '0;
                  rsp_in.entries_held = HW'(count_ff);
               end else if (is_insert) begin
                  // top-down insert along the path to the new slot
                  ins_tok.valid = 1'b1;
                  ins_tok.op    = bmhq_pkg::OP_INS;
                  ins_tok.node  = NW'(1);
                  ins_tok.key   = req_data.key_in;
                  ins_tok.limit = count_ff + NW'(1);
                  ins_tok.path  = node_path(count_ff + NW'(1));
                  ins_in        = 1'b1;
                  state_in      = ST_WAIT;
               end else if (heap_empty) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = bmhq_pkg::STAT_EMPTY;
                  rsp_in.key_out      = '0;
                  rsp_in.entries_held = HW'(count_ff);
               end else begin
                  // read the root, and the last entry on an extract
                  probe_go = 1'b1;
                  ins_in   = 1'b0;
                  ext_in   = is_extract;
                  dc_in    = last_level;
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (!ext_ff || (count_less == '0)) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = bmhq_pkg::STAT_MINIMUM;
               rsp_in.key_out      = $signed(root_key);
               rsp_in.entries_held = ext_ff ? HW'(count_less) : HW'(count_ff);
               count_in            = ext_ff ? count_less : count_ff;
               state_in            = ST_IDLE;
            end else begin
               // last entry moves into the root and sinks from level one on
               del_tok.valid = 1'b1;
               del_tok.op    = bmhq_pkg::OP_DEL;
               del_tok.node  = NW'(1);
               del_tok.key   = $signed(probe_key_vec[dc_ff]);
               del_tok.limit = count_less;
               del_tok.path  = '0;
               count_in      = count_less;
               root_in       = root_key;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (any_done) begin
               rsp_valid_in = 1'b1;
               if (ins_ff) begin
                  count_in            = count_ff + NW'(1);
                  rsp_in.status       = bmhq_pkg::STAT_INSERTED;
                  rsp_in.key_out      = '0;
                  rsp_in.entries_held = HW'(count_ff + NW'(1));
               end else begin
                  rsp_in.status       = bmhq_pkg::STAT_MINIMUM;
                  rsp_in.key_out      = $signed(root_ff);
                  rsp_in.entries_held = HW'(count_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ins_ff       <= 1'b0;
         ext_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         ins_ff       <= ins_in;
         ext_ff       <= ext_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      dc_ff   <= dc_in;
      root_ff <= root_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // chain of level cells, each with its own row memory
   for (genvar l = 0; l < L; l++) begin : g_level
      localparam int ROWS = (l == 0) ? 1 :
                            (l < L - 1) ? (1 << (l - 1)) :
                            ((CAP - (1 << (L - 1)) + 2) >> 1);
      localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

      logic [AW-1:0] rd_addr, wr_addr;

      if (l < 2) begin : g_single_row
         assign rd_addr = '0;
         assign wr_addr = '0;
      end else begin : g_rows
         assign rd_addr = ram_vec[l].rd_row[AW-1:0];
         assign wr_addr = ram_vec[l].wr_row[AW-1:0];
      end

      // token entry: insert at the root, sift-down at level one
      if (l == 0) begin : g_tok_root
         assign tok_in_vec[l] = ins_tok;
      end else if (l == 1) begin : g_tok_first
         assign tok_in_vec[l] = tok_out_vec[0].valid ? tok_out_vec[0] : del_tok;
      end else begin : g_tok_chain
         assign tok_in_vec[l] = tok_out_vec[l-1];
      end

      // parent fills come up from the level below
      if (l < L - 1) begin : g_wup_chain
         assign wup_in_vec[l] = wup_out_vec[l+1];
      end else begin : g_wup_last
         assign wup_in_vec[l] = '0;
      end

      assign probe_vec[l].en   = probe_go && ((l == 0) || (is_extract && (last_level == LW'(l))));
      assign probe_vec[l].node = (l == 0) ? NW'(1) : count_ff;

      bmhq_ram #(
         .DEPTH (ROWS)
      ) u_ram (
         .clock   (clock),
         .rd_en   (ram_vec[l].rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_data_vec[l]),
         .wr_lane (ram_vec[l].wr_lane),
         .wr_addr (wr_addr),
         .wr_key  (ram_vec[l].wr_key)
      );

      bmhq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_in    (tok_in_vec[l]),
         .wup_in    (wup_in_vec[l]),
         .probe_in  (probe_vec[l]),
         .rd_data   (rd_data_vec[l]),
         .ram       (ram_vec[l]),
         .tok_out   (tok_out_vec[l]),
         .wup_out   (wup_out_vec[l]),
         .done      (done_vec[l]),
         .probe_key (probe_key_vec[l])
      );
   end

   // the result strobe only comes with the sequencer back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // entry count stays within capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(CAP))
      else $error("entry count above capacity");

   // an accepted item either gives its result next or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted item lost");

   // no two cells finish a token in the same cycle
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(done_vec))
      else $error("more than one cell finished");

   // a finished walk is reported in the next cycle
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WAIT) && any_done) |=> rsp_valid)
      else $error("finished walk without result");

   // full status only when the heap is at capacity
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == bmhq_pkg::STAT_FULL)) |-> (count_ff == NW'(CAP)))
      else $error("full reported below capacity");

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench for the binary min-heap queue core: directed and random items against a heap model
module tb;
   import bmhq_pkg::*;

   // action code 3 is unused by the package and must act as a peek
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_LOWEST  = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_HIGHEST = {1'b0, {(KEY_W-1){1'b1}}};

   localparam int RANDOM_ITEMS   = 900;
   localparam int SETTLE_CYCLES  = 16;
   localparam int QUIET_LIMIT    = 2000;  // longest sender gap plus latency, many times over
   localparam int REPORT_LINES   = 40;

   // one queued item, optionally held back until every result is back
   typedef struct {
      req_type item;
      bit      drain_first;
   } pending_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_type pending_ops[$];
   rsp_type     expected_results[$];

   // heap model state
   logic signed [KEY_W-1:0] heap_keys [CAPACITY];
   int heap_size = 0;

   // planned entry count, used only to shape the stimulus
   int plan_count = 0;

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int idle_left      = 0;
   int calm_left      = 0;

   binary_min_heap_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // apply one item to the heap model and return the result it must give
   function automatic rsp_type apply_heap_op(req_type item);
      rsp_type res;
      int pos;
      int up;
      int kid;
      bit moving;
      logic signed [KEY_W-1:0] tmp;
      res = '0;
      if (item.action == ACT_INSERT) begin
         if (heap_size >= CAPACITY) begin
            res.status = STAT_FULL;
         end else begin
            // new key goes after the last entry and rises while its parent is larger
            pos = heap_size;
            heap_keys[pos] = item.key_in;
            moving = 1'b1;
            while (moving && pos > 0) begin
               up = (pos - 1) / 2;
               if (heap_keys[up] > heap_keys[pos]) begin
                  tmp = heap_keys[up];
                  heap_keys[up] = heap_keys[pos];
                  heap_keys[pos] = tmp;
                  pos = up;
               end else begin
                  moving = 1'b0;
               end
            end
            heap_size++;
            res.status = STAT_INSERTED;
         end
      end else if (heap_size == 0) begin
         res.status = STAT_EMPTY;
      end else begin
         // extract, peek and the spare code all return the root
         res.status  = STAT_MINIMUM;
         res.key_out = heap_keys[0];
         if (item.action == ACT_EXTRACT) begin
            // last entry moves to the root and sinks, smaller child first, ties to the left
            heap_keys[0] = heap_keys[heap_size-1];
            heap_size--;
            pos = 0;
            moving = 1'b1;
            while (moving && 2*pos + 1 < heap_size) begin
               kid = 2*pos + 1;
               if (kid + 1 < heap_size && heap_keys[kid] > heap_keys[kid+1])
                  kid++;
               if (heap_keys[pos] > heap_keys[kid]) begin
                  tmp = heap_keys[pos];
                  heap_keys[pos] = heap_keys[kid];
                  heap_keys[kid] = tmp;
                  pos = kid;
               end else begin
                  moving = 1'b0;
               end
            end
         end
      end
      res.entries_held = HELD_W'(heap_size);
      return res;
   endfunction

   // keys: full range, a narrow band for duplicates, the extremes, a moderate band
   function automatic logic signed [KEY_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return $urandom();
      else if (r < 70)
         return $signed($urandom_range(0, 16)) - 8;
      else if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return KEY_LOWEST;
            1: return KEY_HIGHEST;
            2: return '0;
            default: return '1;
         endcase
      end else
         return $signed($urandom_range(0, 2000)) - 1000;
   endfunction

   // sender gap after an item: mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   task automatic queue_op(logic [ACTION_W-1:0] action, logic signed [KEY_W-1:0] key,
                           bit drain_first);
      pending_type op;
      op.item.action = action;
      op.item.key_in = key;
      op.drain_first = drain_first;
      pending_ops.push_back(op);
      if (action == ACT_INSERT && plan_count < CAPACITY)
         plan_count++;
      else if (action == ACT_EXTRACT && plan_count > 0)
         plan_count--;
   endtask

   // a run of random items with the given insert and extract shares in percent
   task automatic queue_mix(int count, int insert_pct, int extract_pct, bit drain_first);
      int unsigned r;
      logic [ACTION_W-1:0] action;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < insert_pct)
            action = ACT_INSERT;
         else if (r < insert_pct + extract_pct)
            action = ACT_EXTRACT;
         else if ($urandom_range(0, 3) == 0)
            action = ACT_SPARE;
         else
            action = ACT_PEEK;
         queue_op(action, pick_key(), drain_first && i == 0);
      end
   endtask

   task automatic flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
      if (mismatch_count < REPORT_LINES)
         $display("tb: mismatch in %s at %0t: expected %h, got %h", field, $time, want, got);
      mismatch_count++;
   endtask

   // driver: presents pending items, predicts each one at the edge that takes it
   always @(posedge clock) begin
      logic taken;
      logic send;
      pending_type op;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
         calm_left = 0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            expected_results.push_back(apply_heap_op(req_data));
            // calm stretches keep the block fed back to back
            if (calm_left > 0) begin
               calm_left--;
               idle_left = 0;
            end else begin
               idle_left = pick_gap();
               if ($urandom_range(0, 39) == 0)
                  calm_left = $urandom_range(20, 80);
            end
         end
         send = 1'b0;
         if (!start || taken) begin
            if (idle_left > 0)
               idle_left--;
            else if (pending_ops.size() != 0) begin
               // a marked item waits until the block has nothing left in flight
               if (!(pending_ops[0].drain_first && expected_results.size() != 0))
                  send = 1'b1;
            end
         end
         if (send) begin
            op = pending_ops.pop_front();
            req_data <= op.item;
            start    <= 1'b1;
         end else if (!start || taken) begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result is checked against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            flag_mismatch("unexpected result", '0, 64'(rsp_data));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch("status", 64'(want.status), 64'(rsp_data.status));
            if (rsp_data.key_out !== want.key_out)
               flag_mismatch("key_out", 64'(want.key_out), 64'(rsp_data.key_out));
            if (rsp_data.entries_held !== want.entries_held)
               flag_mismatch("entries_held", 64'(want.entries_held),
                             64'(rsp_data.entries_held));
         end
      end
   end

   // watchdog on cycles in which neither an item nor a result is taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int random_done;
      bit filled;
      int unsigned kind;
      int len;

      // directed: empty heap, extreme and repeated keys, spare code, full drain
      queue_op(ACT_PEEK, $urandom(), 1'b0);
      queue_op(ACT_EXTRACT, $urandom(), 1'b0);
      queue_op(ACT_SPARE, $urandom(), 1'b0);
      queue_op(ACT_INSERT, '0, 1'b0);
      queue_op(ACT_INSERT, KEY_HIGHEST, 1'b0);
      queue_op(ACT_INSERT, KEY_LOWEST, 1'b0);
      queue_op(ACT_INSERT, '1, 1'b0);
      queue_op(ACT_INSERT, 32'sd1, 1'b0);
      queue_op(ACT_INSERT, KEY_HIGHEST, 1'b0);
      queue_op(ACT_INSERT, KEY_LOWEST, 1'b0);
      queue_op(ACT_INSERT, 32'sd5, 1'b0);
      queue_op(ACT_INSERT, 32'sd5, 1'b0);
      queue_op(ACT_PEEK, $urandom(), 1'b0);
      queue_op(ACT_SPARE, $urandom(), 1'b0);
      while (plan_count > 0)
         queue_op(ACT_EXTRACT, $urandom(), 1'b0);
      queue_op(ACT_EXTRACT, $urandom(), 1'b0);

      // random phases, with one fill to capacity and drain to empty on the way
      random_done = 0;
      filled = 1'b0;
      while (random_done < RANDOM_ITEMS) begin
         if (!filled && random_done >= 300) begin
            len = pending_ops.size();
            queue_op(ACT_INSERT, pick_key(), 1'b1);
            while (plan_count < CAPACITY)
               queue_op(ACT_INSERT, pick_key(), 1'b0);
            // inserts into a full heap are dropped
            repeat ($urandom_range(2, 5))
               queue_op(ACT_INSERT, pick_key(), 1'b0);
            queue_op(ACT_PEEK, $urandom(), 1'b0);
            while (plan_count > 0) begin
               if ($urandom_range(0, 9) == 0)
                  queue_op(ACT_PEEK, $urandom(), 1'b0);
               queue_op(ACT_EXTRACT, $urandom(), 1'b0);
            end
            queue_op(ACT_EXTRACT, $urandom(), 1'b0);
            queue_op(ACT_SPARE, $urandom(), 1'b0);
            random_done += pending_ops.size() - len;
            filled = 1'b1;
         end else begin
            len  = $urandom_range(30, 80);
            kind = $urandom_range(0, 2);
            case (kind)
               0: queue_mix(len, 50, 35, $urandom_range(0, 2) == 0);
               1: queue_mix(len, 75, 15, $urandom_range(0, 2) == 0);
               default: queue_mix(len, 20, 70, $urandom_range(0, 2) == 0);
            endcase
            random_done += len;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || start)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
